// ===== hw/rtl/clad_pkg.sv =====
// Shared types and codes for the circular list block.
// Holds the command, status and controller state encodings; no dependencies.
package clad_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_LISTED   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

// ===== hw/rtl/clad_ram.sv =====
// Entry store of the circular list: one write port, one read port,
// registered read data. Depends on clad_pkg for the data width.
module clad_ram import clad_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/clad_ctrl.sv =====
// Command sequencer of the circular list: append, search-and-compact delete
// and list walk over the entry store. Depends on clad_pkg.
module clad_ctrl import clad_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command,
  input  logic signed [DATA_W-1:0] value,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] item_value,
  output logic [2:0]               status,
  output logic                     last,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic signed [DATA_W-1:0] mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic signed [DATA_W-1:0] mem_rdata
);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t                   state;
  cmd_t                     op;
  logic signed [DATA_W-1:0] req_value;
  logic [CW-1:0]            count;
  logic [CW-1:0]            iss;
  logic [CW-1:0]            pend_idx;
  logic                     pend_valid;
  logic                     found;
  logic                     final_item;
  logic                     match;
  logic [CW-1:0]            pend_m1;

  assign busy       = (state != S_IDLE);
  assign final_item = ((pend_idx + CW'(1)) == count);
  assign match      = (mem_rdata == req_value);
  assign pend_m1    = pend_idx - CW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = value;
    mem_re    = 1'b0;
    mem_raddr = iss[AW-1:0];
    if (state == S_IDLE && start && command == CMD_APPEND && count != CAP_C) begin
      mem_we = 1'b1;
    end
    if (state == S_SCAN && iss < count) begin
      mem_re = 1'b1;
    end
    if (state == S_SCAN && pend_valid && found && op == CMD_DELETE) begin
      mem_we    = 1'b1;
      mem_waddr = pend_m1[AW-1:0];
      mem_wdata = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      strobe     <= 1'b0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      pend_valid <= mem_re;
      case (state)
        S_IDLE: begin
          if (start) begin
            op        <= cmd_t'(command);
            req_value <= value;
            iss       <= '0;
            found     <= 1'b0;
            case (command) inside
              CMD_APPEND: begin
                strobe     <= 1'b1;
                last       <= 1'b1;
                item_value <= value;
                if (count == CAP_C) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_APPENDED;
                  count  <= count + CW'(1);
                end
              end
              CMD_DELETE, CMD_LIST: begin
                if (count == '0) begin
                  strobe     <= 1'b1;
                  last       <= 1'b1;
                  item_value <= value;
                  status     <= ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            iss <= iss + CW'(1);
          end
          pend_idx <= iss;
          if (pend_valid) begin
            if (op == CMD_LIST) begin
              strobe     <= 1'b1;
              item_value <= mem_rdata;
              status     <= ST_LISTED;
              last       <= final_item;
              if (final_item) begin
                state <= S_IDLE;
              end
            end else begin
              if (!found && match) begin
                found <= 1'b1;
              end
              if (final_item) begin
                strobe     <= 1'b1;
                last       <= 1'b1;
                item_value <= req_value;
                state      <= S_IDLE;
                if (found || match) begin
                  status <= ST_DELETED;
                  count  <= count - CW'(1);
                end else begin
                  status <= ST_NOTFOUND;
                end
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/circular_list_append_delete.sv =====
// Top level of the bounded ordered list of signed 32-bit values.
// Instantiates clad_ctrl and clad_ram; depends on clad_pkg.
//
// A request is taken at a rising edge with start high and busy low; command
// selects append, delete or list, value carries the operand. Results appear
// for exactly one cycle with strobe high and must be taken then; last marks
// the final result of a request.
// Append answers in the cycle after the request.
// Delete and list walk the entry store through its single read port, one
// entry per cycle: each entry passes the registered read data of the store
// and then the result register before it appears, and listed entries then
// follow one per cycle. Delete shifts later entries down during the same
// walk, writing one entry behind the read. Empty and full cases answer in
// the cycle after the request. Command code 3 is taken and dropped without
// a result.
// A synchronous reset empties the list; no clearing pass is needed.
module circular_list_append_delete import clad_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command,
  input  logic signed [DATA_W-1:0] value,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] item_value,
  output logic [2:0]               status,
  output logic                     last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  clad_ctrl #(
    .CAPACITY(CAPACITY),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .value(value),
    .strobe(strobe),
    .item_value(item_value),
    .status(status),
    .last(last),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  clad_ram #(
    .DEPTH(CAPACITY),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
